@@ src/mesi_pkg.sv @@
// Shared types, codes and default sizes of the MESI cache tag controller.
package mesi_pkg;

   localparam int SET_BITS_DEFAULT   = 6;
   localparam int WAYS_DEFAULT       = 2;
   localparam int BLOCK_BITS_DEFAULT = 5;

   localparam int ADDR_W     = 32;
   localparam int ACTION_W   = 3;
   localparam int RSP_DATA_W = 80;

   localparam logic [ACTION_W-1:0] ACT_CORE_READ     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CORE_WRITE    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SNOOP_READ    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SNOOP_READ_EX = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SNOOP_INVAL   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_FILL          = 3'd5;

   typedef enum logic [1:0] {
      MESI_I,
      MESI_S,
      MESI_E,
      MESI_M
   } mesi_state_type;

   typedef enum logic [1:0] {
      BUS_NONE,
      BUS_READ,
      BUS_READ_EX
   } bus_req_type;

   // Declared from the top bit down, so hit lands in bit 0 of the stream word.
   typedef struct packed {
      logic [5:0]  pad;
      logic        snoop_invalidated;
      logic        snoop_supplied;
      logic [31:0] evicted_address;
      logic        writeback;
      logic        eviction;
      logic        fill_accepted;
      logic        ignored;
      logic [31:0] request_address;
      bus_req_type bus_request;
      logic        miss;
      logic        hit;
   } rsp_type;

   typedef struct packed {
      logic first;
      logic step;
   } scan_ctrl_type;

   typedef struct packed {
      logic hit;
      logic invalid;
   } scan_flags_type;

endpackage

@@ src/mesi_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module mesi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mesi_scan.sv @@
// Shared way comparator: looks at one way per cycle and keeps hit, free and LRU candidates.
module mesi_scan #(
   parameter int TAG_W  = 21,
   parameter int RANK_W = 1,
   parameter int WAY_W  = 1
) (
   input  logic                     clock,
   input  mesi_pkg::scan_ctrl_type  ctrl,
   input  logic [WAY_W-1:0]         way_idx,
   input  logic [TAG_W-1:0]         ent_tag,
   input  mesi_pkg::mesi_state_type ent_mesi,
   input  logic [RANK_W-1:0]        ent_rank,
   input  logic [TAG_W-1:0]         cmp_tag,
   output mesi_pkg::scan_flags_type flags,
   output logic [WAY_W-1:0]         hit_way,
   output logic [WAY_W-1:0]         inv_way,
   output logic [WAY_W-1:0]         best_way
);

   import mesi_pkg::*;

   scan_flags_type    flags_ff, flags_in, prev_flags;
   logic [WAY_W-1:0]  hit_way_ff, hit_way_in;
   logic [WAY_W-1:0]  inv_way_ff, inv_way_in;
   logic [WAY_W-1:0]  best_way_ff, best_way_in;
   logic [RANK_W-1:0] best_rank_ff, best_rank_in;
   logic              is_valid;
   logic              tag_match;

   assign is_valid  = (ent_mesi != MESI_I);
   assign tag_match = is_valid && (ent_tag == cmp_tag);

   always_comb begin
      prev_flags   = ctrl.first ? '0 : flags_ff;
      flags_in     = prev_flags;
      hit_way_in   = hit_way_ff;
      inv_way_in   = inv_way_ff;
      best_way_in  = best_way_ff;
      best_rank_in = best_rank_ff;
      if (tag_match && !prev_flags.hit) begin
         flags_in.hit = 1'b1;
         hit_way_in   = way_idx;
      end
      if (!is_valid && !prev_flags.invalid) begin
         flags_in.invalid = 1'b1;
         inv_way_in       = way_idx;
      end
      // Strictly greater keeps the lowest way on equal ranks.
      if (ctrl.first || (ent_rank > best_rank_ff)) begin
         best_way_in  = way_idx;
         best_rank_in = ent_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         flags_ff     <= flags_in;
         hit_way_ff   <= hit_way_in;
         inv_way_ff   <= inv_way_in;
         best_way_ff  <= best_way_in;
         best_rank_ff <= best_rank_in;
      end
   end

   assign flags    = flags_ff;
   assign hit_way  = hit_way_ff;
   assign inv_way  = inv_way_ff;
   assign best_way = best_way_ff;

endmodule

@@ src/mesi_set_assoc_cache_controller.sv @@
// Top level of the MESI set-associative cache tag and state controller.
//
// Requests come in on req_*: req_tuser carries the action (core read, core write,
// snoop read, snoop read-exclusive, snoop invalidate, fill done) and req_tdata the
// byte address. Each request gives exactly one response on rsp_*, a packed word of
// hit, miss, bus request, eviction, write-back and snoop outcome flags.
// The tags, states, dirty bits and LRU ranks of one set live in one RAM row.
// A request reads its row, then one shared comparator walks the ways, one way a
// cycle, and the updated row is written back while the response is loaded.
// A new request is accepted only once the last one has passed its way walk and its
// update, so requests do not overlap in the controller. The response is registered
// and becomes valid the cycle after its row is written back.
// After reset the block sweeps the RAM to clear every set, one set a cycle, with
// req_tready low. A stalled response stays in the output register; the next request
// may still be accepted and worked on, and it waits at its write-back until the
// output register is free.
module mesi_set_assoc_cache_controller #(
   parameter int SET_BITS   = mesi_pkg::SET_BITS_DEFAULT,
   parameter int WAYS       = mesi_pkg::WAYS_DEFAULT,
   parameter int BLOCK_BITS = mesi_pkg::BLOCK_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mesi_pkg::ADDR_W-1:0]     req_tdata,  // address[31:0]
   input  logic [mesi_pkg::ACTION_W-1:0]   req_tuser,  // action[2:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit[0], miss[1], bus_request[3:2], request_address[35:4], ignored[36],
   // fill_accepted[37], eviction[38], writeback[39], evicted_address[71:40],
   // snoop_supplied[72], snoop_invalidated[73], zero[79:74]
   output logic [mesi_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import mesi_pkg::*;

   localparam int NSETS    = 1 << SET_BITS;
   localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_W    = ADDR_W - SET_BITS - BLOCK_BITS;
   localparam int BLK_W    = ADDR_W - BLOCK_BITS;
   localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W    = RANK_W;
   localparam int DIRTY_BIT = RANK_W;
   localparam int MESI_LSB = RANK_W + 1;
   localparam int TAG_LSB  = RANK_W + 3;
   localparam int ENTRY_W  = TAG_W + 3 + RANK_W;
   localparam int ROW_W    = WAYS * ENTRY_W;

   localparam logic [SET_W-1:0]          LAST_SET    = SET_W'(NSETS - 1);
   localparam logic [WAY_W-1:0]          LAST_WAY    = WAY_W'(WAYS - 1);
   localparam logic [RANK_W-1:0]         MAX_RANK    = RANK_W'(WAYS - 1);
   localparam logic [ADDR_W-1:0]         OFFSET_MASK = ADDR_W'((1 << BLOCK_BITS) - 1);
   localparam logic [ADDR_W-TAG_W-1:0]   LOW_ZERO    = '0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] s;
      s = a >> BLOCK_BITS;
      return SET_W'(s) & LAST_SET;
   endfunction

   state_type          state_ff, state_in;
   logic [SET_W-1:0]   clear_ff, clear_in;
   logic [WAY_W-1:0]   way_ff, way_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               pend_ff, pend_in;
   logic [BLK_W-1:0]   pend_block_ff, pend_block_in;
   logic               pend_write_ff, pend_write_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               ram_we;
   logic [SET_W-1:0]   ram_waddr;
   logic [ROW_W-1:0]   ram_wdata;
   logic               ram_re;
   logic [SET_W-1:0]   ram_raddr;
   logic [ROW_W-1:0]   ram_rdata;

   scan_ctrl_type      scan_ctrl;
   scan_flags_type     scan_flags;
   logic [WAY_W-1:0]   hit_way, inv_way, best_way;
   logic [ENTRY_W-1:0] sel_entry;

   logic [TAG_W-1:0]   e_tag   [WAYS];
   mesi_state_type     e_mesi  [WAYS];
   logic               e_dirty [WAYS];
   logic [RANK_W-1:0]  e_rank  [WAYS];
   logic [TAG_W-1:0]   n_tag   [WAYS];
   mesi_state_type     n_mesi  [WAYS];
   logic               n_dirty [WAYS];
   logic [RANK_W-1:0]  n_rank  [WAYS];

   rsp_type            rsp_next;
   logic [ROW_W-1:0]   new_row;
   logic               upd_pend;
   logic [BLK_W-1:0]   upd_block;
   logic               upd_write;

   mesi_ram #(
      .WIDTH(ROW_W),
      .DEPTH(NSETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign sel_entry       = ram_rdata[way_ff * ENTRY_W +: ENTRY_W];
   assign scan_ctrl.step  = (state_ff == ST_SCAN);
   assign scan_ctrl.first = (way_ff == '0);

   mesi_scan #(
      .TAG_W  (TAG_W),
      .RANK_W (RANK_W),
      .WAY_W  (WAY_W)
   ) u_mesi_scan (
      .clock    (clock),
      .ctrl     (scan_ctrl),
      .way_idx  (way_ff),
      .ent_tag  (sel_entry[TAG_LSB +: TAG_W]),
      .ent_mesi (mesi_state_type'(sel_entry[MESI_LSB +: 2])),
      .ent_rank (sel_entry[RANK_W-1:0]),
      .cmp_tag  (addr_ff[ADDR_W-1 -: TAG_W]),
      .flags    (scan_flags),
      .hit_way  (hit_way),
      .inv_way  (inv_way),
      .best_way (best_way)
   );

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         e_tag[w]   = ram_rdata[w * ENTRY_W + TAG_LSB +: TAG_W];
         e_mesi[w]  = mesi_state_type'(ram_rdata[w * ENTRY_W + MESI_LSB +: 2]);
         e_dirty[w] = ram_rdata[w * ENTRY_W + DIRTY_BIT];
         e_rank[w]  = ram_rdata[w * ENTRY_W +: RANK_W];
      end
   end

   // Outcome of the request and the new contents of its set.
   always_comb begin
      logic [ADDR_W-1:0] blk_addr;
      logic [SET_W-1:0]  cur_set;
      logic [TAG_W-1:0]  cur_tag;
      logic [WAY_W-1:0]  vic;
      logic [WAY_W-1:0]  tw;
      logic              do_touch;
      logic [RANK_W-1:0] old_rank;
      mesi_state_type    st;

      n_tag     = e_tag;
      n_mesi    = e_mesi;
      n_dirty   = e_dirty;
      n_rank    = e_rank;
      rsp_next  = '0;
      upd_pend  = pend_ff;
      upd_block = pend_block_ff;
      upd_write = pend_write_ff;
      blk_addr  = addr_ff & ~OFFSET_MASK;
      cur_set   = set_of(addr_ff);
      cur_tag   = addr_ff[ADDR_W-1 -: TAG_W];
      st        = scan_flags.hit ? e_mesi[hit_way] : MESI_I;
      vic       = scan_flags.invalid ? inv_way : best_way;
      tw        = hit_way;
      do_touch  = 1'b0;
      old_rank  = '0;

      unique case (action_ff)
         ACT_CORE_READ, ACT_CORE_WRITE: begin
            if (pend_ff) begin
               rsp_next.ignored = 1'b1;
            end else if (action_ff == ACT_CORE_READ) begin
               if (scan_flags.hit) begin
                  do_touch     = 1'b1;
                  rsp_next.hit = 1'b1;
               end else begin
                  rsp_next.miss            = 1'b1;
                  rsp_next.bus_request     = BUS_READ;
                  rsp_next.request_address = blk_addr;
                  upd_pend                 = 1'b1;
                  upd_block                = addr_ff[ADDR_W-1:BLOCK_BITS];
                  upd_write                = 1'b0;
               end
            end else if (st == MESI_M || st == MESI_E) begin
               n_mesi[hit_way]  = MESI_M;
               n_dirty[hit_way] = 1'b1;
               do_touch         = 1'b1;
               rsp_next.hit     = 1'b1;
            end else begin
               // An upgrade from shared still asks the bus but is no miss.
               rsp_next.miss            = (st != MESI_S);
               rsp_next.bus_request     = BUS_READ_EX;
               rsp_next.request_address = blk_addr;
               upd_pend                 = 1'b1;
               upd_block                = addr_ff[ADDR_W-1:BLOCK_BITS];
               upd_write                = 1'b1;
            end
         end
         ACT_SNOOP_READ, ACT_SNOOP_READ_EX, ACT_SNOOP_INVAL: begin
            if (scan_flags.hit) begin
               if (action_ff == ACT_SNOOP_READ) begin
                  rsp_next.snoop_supplied = 1'b1;
                  if (st == MESI_M || st == MESI_E) begin
                     n_mesi[hit_way]  = MESI_S;
                     n_dirty[hit_way] = 1'b0;
                  end
               end else begin
                  rsp_next.snoop_supplied    = (action_ff == ACT_SNOOP_READ_EX) &&
                                               (st == MESI_M);
                  rsp_next.snoop_invalidated = 1'b1;
                  n_mesi[hit_way]            = MESI_I;
                  n_dirty[hit_way]           = 1'b0;
               end
            end
         end
         ACT_FILL: begin
            if (pend_ff && (addr_ff[ADDR_W-1:BLOCK_BITS] == pend_block_ff)) begin
               if (!scan_flags.hit) begin
                  tw = vic;
                  if (e_mesi[vic] != MESI_I) begin
                     rsp_next.eviction = 1'b1;
                     if (e_dirty[vic] && e_mesi[vic] == MESI_M) begin
                        rsp_next.writeback       = 1'b1;
                        rsp_next.evicted_address = {e_tag[vic], LOW_ZERO} |
                                                   (ADDR_W'(cur_set) << BLOCK_BITS);
                     end
                  end
                  n_tag[vic]   = cur_tag;
                  n_dirty[vic] = 1'b0;
               end
               n_mesi[tw] = pend_write_ff ? MESI_M : MESI_S;
               if (pend_write_ff) begin
                  n_dirty[tw] = 1'b1;
               end
               do_touch               = 1'b1;
               upd_pend               = 1'b0;
               rsp_next.fill_accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // The touched way becomes most recent; younger ways age by one.
      if (do_touch) begin
         old_rank = e_rank[tw];
         for (int w = 0; w < WAYS; w++) begin
            if ((WAY_W'(w) != tw) && (e_rank[w] <= old_rank) && (e_rank[w] < MAX_RANK)) begin
               n_rank[w] = e_rank[w] + 1'b1;
            end
         end
         n_rank[tw] = '0;
      end

      for (int w = 0; w < WAYS; w++) begin
         new_row[w * ENTRY_W +: ENTRY_W] = {n_tag[w], n_mesi[w], n_dirty[w], n_rank[w]};
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      way_in        = way_ff;
      action_in     = action_ff;
      addr_in       = addr_ff;
      pend_in       = pend_ff;
      pend_block_in = pend_block_ff;
      pend_write_in = pend_write_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = set_of(addr_ff);
      ram_wdata     = new_row;
      ram_re        = 1'b0;
      ram_raddr     = set_of(req_tdata);

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clear_ff;
            ram_wdata = '0;
            if (clear_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end else begin
               clear_in = clear_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               ram_re    = 1'b1;
               action_in = req_tuser;
               addr_in   = req_tdata;
               way_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (way_ff == LAST_WAY) begin
               state_in = ST_UPDATE;
            end else begin
               way_in = way_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ram_we        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_in        = rsp_next;
               pend_in       = upd_pend;
               pend_block_in = upd_block;
               pend_write_in = upd_write;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      way_ff    <= way_in;
      action_ff <= action_in;
      addr_ff   <= addr_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_ff      <= '0;
         pend_ff       <= 1'b0;
         pend_block_ff <= '0;
         pend_write_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ff      <= clear_in;
         pend_ff       <= pend_in;
         pend_block_ff <= pend_block_in;
         pend_write_ff <= pend_write_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

@@ src/mesi_checker.sv @@
// Port-level assertions for the MESI cache tag controller and their bind.
module mesi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mesi_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import mesi_pkg::*;

   rsp_type rsp_view;

   assign rsp_view = rsp_type'(rsp_tdata);

   // A request keeps the block busy for at least the way walk.
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in the cycle after another request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed or dropped");

   // Eviction and write-back only come with an accepted fill.
   a_fill_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_view.eviction || rsp_view.writeback)
      |-> rsp_view.fill_accepted && (rsp_view.eviction || !rsp_view.writeback))
      else $error("eviction or write-back without an accepted fill");

   a_hit_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.hit
      |-> !rsp_view.miss && (rsp_view.bus_request == BUS_NONE) && !rsp_view.ignored)
      else $error("hit reported together with a miss, bus request or refusal");

endmodule

bind mesi_set_assoc_cache_controller mesi_checker u_mesi_checker (.*);
